// ----- rtl/core/dch_pkg.sv -----
// ----------------------------------------------------------------------------
// dch_pkg
// Shared types and constants of the dominant column height block.
// ----------------------------------------------------------------------------
`default_nettype none

package dch_pkg;

  localparam int COORD_W    = 16;
  localparam int HEIGHT_W   = 16;
  localparam int WIN_W      = 10;
  localparam int MINH_W     = 13;
  localparam int BIAS_W     = 8;
  localparam int SIDE_W     = 17;
  localparam int MC_W       = 13;
  localparam int BIN_W      = 9;
  localparam int SUM_W      = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam int COORD_OFFSET_MM = 13000;
  // x / 10 == (x * 52429) >> 19 for any x below 2^16
  localparam int RECIP_10    = 52429;
  localparam int RECIP_SHIFT = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BIAS  = 2'd2;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 10'd10;
  localparam logic [MINH_W-1:0] MINH_RESET = 13'd1000;
  localparam logic [BIAS_W-1:0] BIAS_RESET = 8'd5;

  typedef struct packed {
    logic clr_step;   // reset sweep of column and histogram memories
    logic load;       // take a point word
    logic lookup;     // column lookup of the held point
    logic col_update; // column max write back
    logic col_rd;     // read and zero one column max
    logic col_eval;   // qualify column max, find its bin
    logic hist_rd;
    logic hist_wr;
    logic srch_step;  // read and zero one bin, feed max search
    logic dom_latch;
    logic acc_step;   // read one stored height for averaging
    logic div_start;
    logic out_load;
    logic set_clear;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic last_clr;
    logic last_col;
    logic last_bin;
    logic last_pt;
    logic last_set;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/dch_ram.sv -----
// ----------------------------------------------------------------------------
// dch_ram
// Simple dual port RAM, one write and one registered read port, read first.
// ----------------------------------------------------------------------------
`default_nettype none

module dch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dch_ctrl.sv -----
// ----------------------------------------------------------------------------
// dch_ctrl
// Sequencer: reset sweep, point load, column pass, bin search, averaging,
// division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dch_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire dch_pkg::sts_t sts_i,
  output dch_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_LD_RD, ST_LD_WR, ST_COL_RD, ST_COL_EV, ST_COL_HR,
    ST_COL_HW, ST_SRCH, ST_SRCH_END, ST_DOM, ST_ACC, ST_ACC_END, ST_DIV_GO,
    ST_DIV_WAIT, ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.last_clr) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd_o.col_update = 1'b1;
        state_d          = sts_i.last_set ? ST_COL_RD : ST_IDLE;
      end
      ST_COL_RD: begin
        cmd_o.col_rd = 1'b1;
        state_d      = ST_COL_EV;
      end
      ST_COL_EV: begin
        cmd_o.col_eval = 1'b1;
        state_d        = ST_COL_HR;
      end
      ST_COL_HR: begin
        cmd_o.hist_rd = 1'b1;
        state_d       = ST_COL_HW;
      end
      ST_COL_HW: begin
        cmd_o.hist_wr = 1'b1;
        if (sts_i.last_col) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SRCH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_COL_RD;
        end
      end
      ST_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.last_bin) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SRCH_END;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SRCH_END: state_d = ST_DOM;
      ST_DOM: begin
        cmd_o.dom_latch = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_step = 1'b1;
        if (sts_i.last_pt) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_ACC_END;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_ACC_END: state_d = ST_DIV_GO;
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          cmd_o.set_clear = 1'b1;
          out_valid_d     = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dch_dpath.sv -----
// ----------------------------------------------------------------------------
// dch_dpath
// Point store, column max table, histogram, bin search, accumulator and
// serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dch_dpath #(
  parameter int MAX_POINTS  = 4096,
  parameter int COLUMNS     = 3000,
  parameter int HEIGHT_BINS = 500
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dch_pkg::cmd_t                     cmd_i,
  output dch_pkg::sts_t                          sts_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dch_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dch_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic signed [dch_pkg::COORD_W-1:0]  coord_i,
  input  wire logic signed [dch_pkg::HEIGHT_W-1:0] height_i,
  input  wire logic                              last_i,
  output logic signed [dch_pkg::SIDE_W-1:0]      side_o,
  output logic [dch_pkg::MC_W-1:0]               matched_o,
  output logic [dch_pkg::BIN_W-1:0]              bin_o,
  output logic                                   status_o
);

  localparam int PAW    = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CAW    = $clog2(COLUMNS);
  localparam int HAW    = $clog2(HEIGHT_BINS);
  localparam int HCW    = $clog2(COLUMNS + 1);
  localparam int CLR_N  = (COLUMNS > HEIGHT_BINS) ? COLUMNS : HEIGHT_BINS;
  localparam int IDX_N  = (CLR_N > MAX_POINTS) ? CLR_N : MAX_POINTS;
  localparam int IW     = $clog2(IDX_N);
  localparam int DCNT_W = $clog2(dch_pkg::SUM_W + 1);
  localparam int HW     = dch_pkg::HEIGHT_W;
  localparam int SW     = dch_pkg::SUM_W;

  // configuration
  logic [dch_pkg::WIN_W-1:0]         win_q;
  logic [dch_pkg::MINH_W-1:0]        minh_q;
  logic signed [dch_pkg::BIAS_W-1:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= dch_pkg::WIN_RESET;
      minh_q <= dch_pkg::MINH_RESET;
      bias_q <= dch_pkg::BIAS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dch_pkg::CFG_MATCH_WINDOW: win_q  <= cfg_data_i[dch_pkg::WIN_W-1:0];
        dch_pkg::CFG_MIN_HEIGHT:   minh_q <= cfg_data_i;
        dch_pkg::CFG_OUTPUT_BIAS:  bias_q <= cfg_data_i[dch_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // sweep index
  logic [IW-1:0] idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // point load
  logic [CNT_W-1:0]      cnt_q;
  logic signed [16:0]    s_q;
  logic signed [HW-1:0]  z_q;
  logic                  stored_q, last_q;
  logic                  room;

  assign room = (cnt_q < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q      <= $signed({coord_i[15], coord_i}) + 17'sd13000;
      z_q      <= height_i;
      stored_q <= room;
      last_q   <= last_i;
    end
  end

  // column lookup: col = s / 10 by reciprocal
  logic [31:0]       cprod;
  logic [12:0]       col_raw, col;
  logic              col_ok;
  logic [CAW-1:0]    col_q;
  logic              colv_q;

  assign cprod   = 32'(s_q[15:0]) * 32'(dch_pkg::RECIP_10);
  assign col_raw = cprod[dch_pkg::RECIP_SHIFT +: 13];
  assign col     = s_q[16] ? 13'd0 : col_raw;
  assign col_ok  = stored_q && (s_q > -17'sd10) && (32'(col) < 32'(COLUMNS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      col_q  <= col[CAW-1:0];
      colv_q <= col_ok;
    end
  end

  // column max memory
  logic           cm_we;
  logic [CAW-1:0] cm_waddr, cm_raddr;
  logic [HW-1:0]  cm_wdata, cm_rdata;

  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = idx_q[CAW-1:0];
    cm_wdata = '0;
    cm_raddr = idx_q[CAW-1:0];
    if (cmd_i.clr_step) begin
      cm_we = (32'(idx_q) < 32'(COLUMNS));
    end else if (cmd_i.col_rd) begin
      cm_we = 1'b1;
    end else if (cmd_i.lookup) begin
      cm_raddr = col[CAW-1:0];
    end else if (cmd_i.col_update) begin
      cm_waddr = col_q;
      cm_wdata = z_q;
      cm_we    = colv_q && ($signed(cm_rdata) < z_q);
    end
  end

  dch_ram #(.WIDTH(HW), .DEPTH(COLUMNS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  // point store
  logic [HW-1:0] ph_rdata;

  dch_ram #(.WIDTH(HW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && room),
    .waddr_i (cnt_q[PAW-1:0]),
    .wdata_i (height_i),
    .raddr_i (idx_q[PAW-1:0]),
    .rdata_o (ph_rdata)
  );

  // column max to bin
  logic signed [HW-1:0] m;
  logic [31:0]          bprod;
  logic [11:0]          bin_raw;
  logic                 qual;
  logic [HAW-1:0]       bin_q;
  logic                 qual_q;

  assign m       = $signed(cm_rdata);
  assign bprod   = 32'(m[14:0]) * 32'(dch_pkg::RECIP_10);
  assign bin_raw = bprod[dch_pkg::RECIP_SHIFT +: 12];
  assign qual    = ($signed({m[15], m}) > $signed({4'b0, minh_q}))
                   && (32'(bin_raw) < 32'(HEIGHT_BINS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_eval) begin
      bin_q  <= bin_raw[HAW-1:0];
      qual_q <= qual;
    end
  end

  // histogram memory
  logic           h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [HCW-1:0] h_wdata, h_rdata;

  always_comb begin
    h_we    = 1'b0;
    h_waddr = idx_q[HAW-1:0];
    h_wdata = '0;
    h_raddr = idx_q[HAW-1:0];
    if (cmd_i.clr_step) begin
      h_we = (32'(idx_q) < 32'(HEIGHT_BINS));
    end else if (cmd_i.srch_step) begin
      h_we = 1'b1;
    end else if (cmd_i.hist_rd) begin
      h_raddr = bin_q;
    end else if (cmd_i.hist_wr) begin
      h_waddr = bin_q;
      h_wdata = h_rdata + HCW'(1);
      h_we    = qual_q;
    end
  end

  dch_ram #(.WIDTH(HCW), .DEPTH(HEIGHT_BINS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // first fullest bin, bin 0 never wins
  logic           sv_q;
  logic [HAW-1:0] si_q;
  logic [HCW-1:0] best_cnt_q;
  logic [HAW-1:0] best_bin_q;
  logic [16:0]    dom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q       <= 1'b0;
      best_cnt_q <= '0;
      best_bin_q <= '0;
    end else begin
      sv_q <= cmd_i.srch_step;
      if (cmd_i.set_clear) begin
        best_cnt_q <= '0;
        best_bin_q <= '0;
      end else if (sv_q && (si_q != '0) && (best_cnt_q < h_rdata)) begin
        best_cnt_q <= h_rdata;
        best_bin_q <= si_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= idx_q[HAW-1:0];
    if (cmd_i.dom_latch) begin
      dom_q <= 17'(best_bin_q) * 17'd10;
    end
  end

  // window match and accumulate
  logic                 av_q;
  logic signed [HW-1:0] h;
  logic signed [17:0]   diff;
  logic [17:0]          adiff;
  logic signed [SW-1:0] sum_q;
  logic [CNT_W-1:0]     mcnt_q;

  assign h     = $signed(ph_rdata);
  assign diff  = $signed({{2{h[15]}}, h}) - $signed({1'b0, dom_q});
  assign adiff = diff[17] ? 18'(-diff) : 18'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q   <= 1'b0;
      sum_q  <= '0;
      mcnt_q <= '0;
      cnt_q  <= '0;
    end else begin
      av_q <= cmd_i.acc_step;
      if (cmd_i.set_clear) begin
        sum_q  <= '0;
        mcnt_q <= '0;
        cnt_q  <= '0;
      end else begin
        if (cmd_i.load && room) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (av_q && (adiff < 18'(win_q))) begin
          sum_q  <= sum_q + SW'(h);
          mcnt_q <= mcnt_q + CNT_W'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [SW-1:0]     abs_sum, dvd;
  logic [SW-1:0]     quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    r2;
  logic [DCNT_W-1:0] dcnt_q;

  assign abs_sum = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign dvd     = abs_sum + SW'(mcnt_q >> 1);
  assign r2      = {rem_q, quo_q[SW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCNT_W'(SW);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= dvd;
      rem_q <= '0;
    end else if (dcnt_q != '0) begin
      if (r2 >= {1'b0, mcnt_q}) begin
        rem_q <= CNT_W'(r2 - {1'b0, mcnt_q});
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= r2[CNT_W-1:0];
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  // result word
  logic signed [dch_pkg::SIDE_W-1:0] avg;
  assign avg = sum_q[SW-1] ? -$signed(quo_q[dch_pkg::SIDE_W-1:0])
                           : $signed(quo_q[dch_pkg::SIDE_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      side_o    <= (mcnt_q == '0) ? '0 : avg + dch_pkg::SIDE_W'(bias_q);
      matched_o <= dch_pkg::MC_W'(mcnt_q);
      bin_o     <= dch_pkg::BIN_W'(best_bin_q);
      status_o  <= (mcnt_q == '0);
    end
  end

  assign sts_o.last_clr = (32'(idx_q) == 32'(CLR_N - 1));
  assign sts_o.last_col = (32'(idx_q) == 32'(COLUMNS - 1));
  assign sts_o.last_bin = (32'(idx_q) == 32'(HEIGHT_BINS - 1));
  assign sts_o.last_pt  = ((32'(idx_q) + 32'd1) == 32'(cnt_q));
  assign sts_o.last_set = last_q;
  assign sts_o.div_busy = (dcnt_q != '0);

endmodule

`default_nettype wire

// ----- rtl/core/dominant_column_height.sv -----
// ----------------------------------------------------------------------------
// dominant_column_height
// Dominant height of a point set from per-column height maxima.
// ----------------------------------------------------------------------------
// Points arrive on the s_axis word channel, one per word, tlast on the final
// point of a set. Each point, up to MAX_POINTS per set, is stored and folded
// into a per-column maximum by a read-modify-write of the column max memory.
// After the last point the block runs the end-of-set passes:
//   column pass (read max, bin it, histogram increment)
//   fullest-bin search
//   window match over the N stored points
//   serial divide for the rounded average
// and then presents one word on m_axis. It holds that word until the
// receiver takes it; no new point is accepted before that.
// The passes clear the column and histogram memories for the next set.
// After reset the block first sweeps those memories to zero and takes no
// point meanwhile; configuration writes are taken at any time and should
// land only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dominant_column_height #(
  parameter int MAX_POINTS  = 4096,
  parameter int COLUMNS     = 3000,
  parameter int HEIGHT_BINS = 500
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dch_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dch_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] column_coord_mm, [31:16] height_mm
  input  wire logic [dch_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [16:0] side_height_mm, [29:17] matched_count, [38:30] dominant_bin
  output logic [dch_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // [0] status
  output logic                                  m_axis_tuser
);

  dch_pkg::cmd_t cmd;
  dch_pkg::sts_t sts;

  logic signed [dch_pkg::SIDE_W-1:0] side;
  logic [dch_pkg::MC_W-1:0]          matched;
  logic [dch_pkg::BIN_W-1:0]         bin;

  dch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dch_dpath #(
    .MAX_POINTS  (MAX_POINTS),
    .COLUMNS     (COLUMNS),
    .HEIGHT_BINS (HEIGHT_BINS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coord_i    ($signed(s_axis_tdata[15:0])),
    .height_i   ($signed(s_axis_tdata[31:16])),
    .last_i     (s_axis_tlast),
    .side_o     (side),
    .matched_o  (matched),
    .bin_o      (bin),
    .status_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, bin, matched, side};

endmodule

`default_nettype wire
